// ===== src/lmst_pkg.sv =====
// Package with the shared constants, types and codes of the LED matrix scan driver.
`timescale 1ns / 1ps

package lmst_pkg;

	// Matrix geometry and dimming period.
	localparam int ROWS       = 5;
	localparam int COLS       = 7;
	localparam int DIM_PERIOD = 4;

	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLS);
	localparam int FC_W  = $clog2(DIM_PERIOD);

	// Stream word widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	typedef logic [1:0]       op_t;
	typedef logic [ROW_W-1:0] row_idx_t;
	typedef logic [COL_W-1:0] col_idx_t;
	typedef logic [1:0]       level_t;
	typedef level_t [COLS-1:0] row_pix_t;

	// Operation codes carried in tuser.
	localparam op_t OP_TICK  = 2'd0;
	localparam op_t OP_WRITE = 2'd1;
	localparam op_t OP_CLEAR = 2'd2;

	// Pixel levels.
	localparam level_t LVL_OFF    = 2'd0;
	localparam level_t LVL_DIM    = 2'd1;
	localparam level_t LVL_BRIGHT = 2'd2;

	// Update command from the pipeline to the frame store.
	typedef struct packed {
		logic     wr_en;
		logic     clr;
		row_idx_t row;
		col_idx_t col;
		level_t   level;
	} store_cmd_t;

endpackage

// ===== src/lmst_frame_store.sv =====
// Frame store of 2-bit pixels with single-pixel writes, full clear and one row read.
`timescale 1ns / 1ps

module lmst_frame_store (
	input  logic                clk,
	input  logic                arst_n,
	input  lmst_pkg::store_cmd_t cmd,
	input  lmst_pkg::row_idx_t  rd_row,
	output lmst_pkg::row_pix_t  rd_pix
);
	import lmst_pkg::*;

	row_pix_t store_q [ROWS];

	// Each pixel is its own register; out-of-range coordinates match no pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				store_q[r] <= '0;
			end
		end else begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					if (cmd.clr) begin
						store_q[r][c] <= LVL_OFF;
					end else if (cmd.wr_en && cmd.row == row_idx_t'(r)
							&& cmd.col == col_idx_t'(c)) begin
						store_q[r][c] <= cmd.level;
					end
				end
			end
		end
	end

	// One row is read for the current scan tick.
	always_comb begin
		rd_pix = store_q[0];
		for (int r = 0; r < ROWS; r++) begin
			if (rd_row == row_idx_t'(r)) begin
				rd_pix = store_q[r];
			end
		end
	end

endmodule

// ===== src/led_matrix_scan_three_level.sv =====
// Top level of the multiplexed LED matrix scan driver with three brightness levels.
// Throughput: one word per cycle unless a tick meets a full result slot; each word passes one
// input register and, for a tick, the result register, with the row read and counter update in between.
// Writes and clears give no result word; they pass the input register and then update the store.
// Reset (arst_n low) clears the frame store, the scan and frame counters and the mode.
`timescale 1ns / 1ps

module led_matrix_scan_three_level (
	input  logic                            clk,
	input  logic                            arst_n,
	// Slave stream: tdata = pixel_column[2:0], pixel_row[5:3], pixel_level[7:6]
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lmst_pkg::IN_TDATA_W-1:0] s_tdata,
	// tuser = operation[1:0]
	input  logic [1:0]                      s_tuser,
	// Master stream: tdata = row_lines_n[4:0], column_levels[11:5],
	// column_drive_enable[18:12], zero padding above
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lmst_pkg::OUT_TDATA_W-1:0] m_tdata,
	// Configuration write channel: wiring_mode
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data
);
	import lmst_pkg::*;

	localparam int FIELDS_W = ROWS + 2 * COLS;

	logic     valid_s1;
	op_t      op_s1;
	col_idx_t col_s1;
	row_idx_t row_s1;
	level_t   lvl_s1;

	logic           wiring_mode_q;
	row_idx_t       scan_row_q;
	logic [FC_W-1:0] frame_count_q;
	logic           dim_flag_q;

	logic                  out_valid_q;
	logic [ROWS-1:0]       out_rows_n_q;
	logic [COLS-1:0]       out_levels_q;
	logic [COLS-1:0]       out_drive_q;

	logic        is_tick;
	logic        out_free;
	logic        s1_go;
	store_cmd_t  cmd;
	row_idx_t    rd_row;
	row_pix_t    rd_pix;
	logic [ROWS-1:0] rows_n;
	logic [COLS-1:0] levels;
	logic [COLS-1:0] drive;
	logic [ROW_W:0]  row_inc;
	logic [FC_W:0]   fc_inc;

	// Configuration is always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiring_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			wiring_mode_q <= cfg_data;
		end
	end

	// Handshake: the input stage moves on unless a tick finds the result slot full.
	assign is_tick  = (op_s1 == OP_TICK);
	assign out_free = !out_valid_q || m_tready;
	assign s1_go    = valid_s1 && (!is_tick || out_free);
	assign s_tready = !valid_s1 || s1_go;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= s_tuser;
			col_s1 <= s_tdata[COL_W-1:0];
			row_s1 <= s_tdata[3 +: ROW_W];
			lvl_s1 <= s_tdata[7:6];
		end
	end

	// Store update command; level three is kept as bright.
	always_comb begin
		cmd.wr_en = s1_go && (op_s1 == OP_WRITE);
		cmd.clr   = s1_go && (op_s1 == OP_CLEAR);
		cmd.row   = row_s1;
		cmd.col   = col_s1;
		cmd.level = (lvl_s1 > LVL_BRIGHT) ? LVL_BRIGHT : lvl_s1;
	end

	// Rotated wiring reads the mirrored row.
	assign rd_row = wiring_mode_q ? scan_row_q : (row_idx_t'(ROWS - 1) - scan_row_q);

	lmst_frame_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd_row (rd_row),
		.rd_pix (rd_pix)
	);

	// Column and row line values for the current tick.
	always_comb begin
		level_t p;
		p = LVL_OFF;
		for (int c = 0; c < COLS; c++) begin
			if (wiring_mode_q) begin
				p = rd_pix[c];
				drive[c]  = (p != LVL_DIM);
				levels[c] = (p != LVL_OFF);
			end else begin
				p = rd_pix[COLS - 1 - c];
				drive[c]  = 1'b1;
				levels[c] = (p >= LVL_BRIGHT) || (p == LVL_DIM && dim_flag_q);
			end
		end
		for (int r = 0; r < ROWS; r++) begin
			rows_n[r] = (scan_row_q != row_idx_t'(r));
		end
	end

	// The scan row advances on each tick taken into the result register; the frame counter advances when the row wraps.
	assign row_inc = {1'b0, scan_row_q} + (ROW_W + 1)'(1);
	assign fc_inc  = {1'b0, frame_count_q} + (FC_W + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q    <= '0;
			frame_count_q <= '0;
			dim_flag_q    <= 1'b0;
		end else if (s1_go && is_tick) begin
			if (row_inc >= (ROW_W + 1)'(ROWS)) begin
				scan_row_q <= '0;
				if (fc_inc >= (FC_W + 1)'(DIM_PERIOD)) begin
					frame_count_q <= '0;
					dim_flag_q    <= 1'b1;
				end else begin
					frame_count_q <= fc_inc[FC_W-1:0];
					dim_flag_q    <= 1'b0;
				end
			end else begin
				scan_row_q <= row_inc[ROW_W-1:0];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_go && is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && is_tick) begin
			out_rows_n_q <= rows_n;
			out_levels_q <= levels;
			out_drive_q  <= drive;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - FIELDS_W)'(0), out_drive_q, out_levels_q, out_rows_n_q};

endmodule

// ===== src/lmst_checker.sv =====
// Port-level checker for the LED matrix scan driver, bound to the top level.
`timescale 1ns / 1ps

module lmst_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [lmst_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic [1:0]                       s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [lmst_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic                             cfg_data
);
	import lmst_pkg::*;

	// Exactly one row line is pulled low in every result word.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tdata[ROWS-1:0]) == ROWS - 1)
	else $error("row lines do not have exactly one active row");

	// A released column driver always shows a high level.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((~m_tdata[ROWS + 2*COLS - 1 : ROWS + COLS])
			& (~m_tdata[ROWS + COLS - 1 : ROWS])) == '0)
	else $error("released column driver with a low level");

	// Padding bits of the result word stay zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1 : ROWS + 2*COLS] == '0)
	else $error("nonzero padding in result word");

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	else $error("stalled result word changed");

endmodule

bind led_matrix_scan_three_level lmst_checker u_lmst_checker (.*);

// ===== dv/led_matrix_scan_three_level_tb.sv =====
// Self-checking testbench for the LED matrix scan driver: stream stimulus, prediction and checking.
`timescale 1ns / 1ps

module led_matrix_scan_three_level_tb;

	import lmst_pkg::*;

	// The package leaves the fourth operation code unnamed; the block must ignore it.
	localparam op_t OP_UNUSED = 2'd3;

	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_WORDS   = 350;

	// One result word as it sits in m_tdata, lowest field last.
	typedef struct packed {
		logic [COLS-1:0] drive;
		logic [COLS-1:0] levels;
		logic [ROWS-1:0] row_n;
	} scan_out_t;

	// Tracks the frame store and scan counters and holds the scan words still owed.
	class scan_scoreboard;
		level_t    pix [COLS][ROWS];
		int        scan_row;
		int        frame_count;
		bit        dim_frame;
		bit        wiring_mode;
		scan_out_t expected_scans [$];
		int        errors;

		function new();
			foreach (pix[c, r]) pix[c][r] = LVL_OFF;
			scan_row    = 0;
			frame_count = 0;
			dim_frame   = 1'b0;
			wiring_mode = 1'b0;
			errors      = 0;
		endfunction

		function void set_mode(bit mode);
			wiring_mode = mode;
		endfunction

		function int pending();
			return expected_scans.size();
		endfunction

		// Builds the row and column drive for the current scan row, then steps the row.
		function scan_out_t predict_scan();
			scan_out_t s;
			level_t    p;
			s.row_n           = '1;
			s.row_n[scan_row] = 1'b0;
			s.levels          = '0;
			s.drive           = '0;
			for (int c = 0; c < COLS; c++) begin
				if (wiring_mode) begin
					// Direct wiring: a dim pixel releases its driver and lets the pull-up glow.
					p = pix[c][scan_row];
					s.drive[c]  = (p != LVL_DIM);
					s.levels[c] = (p != LVL_OFF);
				end else begin
					// Rotated wiring: dim pixels light only in the dim frame.
					p = pix[COLS-1-c][ROWS-1-scan_row];
					s.drive[c]  = 1'b1;
					s.levels[c] = (p >= LVL_BRIGHT) || (p == LVL_DIM && dim_frame);
				end
			end
			scan_row++;
			if (scan_row >= ROWS) begin
				scan_row = 0;
				if (frame_count + 1 >= DIM_PERIOD) begin
					frame_count = 0;
					dim_frame   = 1'b1;
				end else begin
					frame_count++;
					dim_frame = 1'b0;
				end
			end
			return s;
		endfunction

		// Applies one accepted input word to the predicted state.
		function void note_word(op_t op, col_idx_t col, row_idx_t row, level_t lvl);
			case (op)
				OP_TICK: begin
					expected_scans.push_back(predict_scan());
				end
				OP_WRITE: begin
					if (col < COLS && row < ROWS)
						pix[col][row] = (lvl > LVL_BRIGHT) ? LVL_BRIGHT : lvl;
				end
				OP_CLEAR: begin
					foreach (pix[c, r]) pix[c][r] = LVL_OFF;
				end
				default: begin
				end
			endcase
		endfunction

		// Only the first few mismatches are printed so a broken build cannot flood the log.
		task report(string msg);
			if (errors < 40)
				$display("MISMATCH: %s", msg);
			errors++;
		endtask

		// Compares one accepted result word with the oldest expected scan.
		task check_word(logic [OUT_TDATA_W-1:0] w);
			scan_out_t want;
			scan_out_t got;
			if (expected_scans.size() == 0) begin
				report($sformatf("result word %h with no scan tick pending", w));
				return;
			end
			want = expected_scans.pop_front();
			got  = w[$bits(scan_out_t)-1:0];
			if (got.row_n !== want.row_n)
				report($sformatf("row lines %b, expected %b", got.row_n, want.row_n));
			if (got.levels !== want.levels)
				report($sformatf("column levels %b, expected %b", got.levels, want.levels));
			if (got.drive !== want.drive)
				report($sformatf("column drive %b, expected %b", got.drive, want.drive));
			if (w[OUT_TDATA_W-1:$bits(scan_out_t)] !== '0)
				report($sformatf("padding bits not zero in word %h", w));
		endtask
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic [1:0]             s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_data  = 1'b0;

	bit no_idle       = 1'b0;
	bit long_hold_req = 1'b0;

	scan_scoreboard sb = new();

	led_matrix_scan_three_level i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Free-running clock.
	initial begin
		forever #4 clk = ~clk;
	end

	// Result monitor: every accepted word is checked against the oldest expected scan.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata);
	end

	// Receiver: random stall bursts, one long hold on request, steady ready at the end.
	initial begin
		int hold_cycles;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				m_tready <= 1'b0;
				for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
					@(posedge clk);
				long_hold_req = 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Offers one input word, waits for it to be taken, then may idle for a burst.
	task automatic send_word(op_t op, col_idx_t col, row_idx_t row, level_t lvl);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {lvl, row, col};
		do @(posedge clk); while (!s_tready);
		sb.note_word(op, col, row, lvl);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Writes the wiring mode; only called while the block is idle.
	task automatic write_mode(bit mode);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_mode(mode);
	endtask

	// Waits for every owed scan word, then lets a trailing store update settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly ticks and in-range pixel writes, with some clears and ignored noise words.
	task automatic send_random_word(output bit ignored);
		int       pick;
		op_t      op;
		col_idx_t col;
		row_idx_t row;
		level_t   lvl;
		pick    = $urandom_range(0, 99);
		op      = OP_WRITE;
		col     = col_idx_t'($urandom_range(0, COLS - 1));
		row     = row_idx_t'($urandom_range(0, ROWS - 1));
		lvl     = level_t'($urandom);
		ignored = 1'b0;
		if (pick < 45) begin
			// Tick fields carry junk that the block must not look at.
			op  = OP_TICK;
			col = col_idx_t'($urandom);
			row = row_idx_t'($urandom);
		end else if (pick < 85) begin
			op = OP_WRITE;
		end else if (pick < 91) begin
			col     = col_idx_t'($urandom);
			row     = row_idx_t'($urandom);
			ignored = (col >= COLS) || (row >= ROWS);
		end else if (pick < 93) begin
			op = OP_CLEAR;
		end else begin
			op      = OP_UNUSED;
			col     = col_idx_t'($urandom);
			row     = row_idx_t'($urandom);
			ignored = 1'b1;
		end
		send_word(op, col, row, lvl);
	endtask

	// One configuration setting followed by a run of random words.
	task automatic run_phase(bit mode, int words);
		int done;
		bit ignored;
		write_mode(mode);
		done = 0;
		while (done < words) begin
			send_random_word(ignored);
			if (!ignored)
				done++;
		end
		drain();
	endtask

	// Main sequence: reset, directed corner words, then random phases over both modes.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);

		// Empty store straight after reset.
		send_word(OP_TICK, '0, '0, LVL_OFF);
		// Corner pixels, a level of three, and writes outside the matrix.
		send_word(OP_WRITE, '0, '0, LVL_BRIGHT);
		send_word(OP_WRITE, col_idx_t'(COLS - 1), row_idx_t'(ROWS - 1), LVL_DIM);
		send_word(OP_WRITE, col_idx_t'(COLS - 1), '0, '1);
		send_word(OP_WRITE, '0, row_idx_t'(ROWS - 1), LVL_BRIGHT);
		send_word(OP_WRITE, 3'd3, 3'd2, LVL_DIM);
		send_word(OP_WRITE, '1, '0, LVL_BRIGHT);
		send_word(OP_WRITE, '0, row_idx_t'(ROWS), LVL_BRIGHT);
		send_word(OP_WRITE, '1, '1, '1);
		// Unknown operation with every field bit set.
		send_word(OP_UNUSED, '1, '1, '1);
		// Two full frames of ticks, with the unused fields toggling.
		for (int i = 0; i < 2 * ROWS; i++)
			send_word(OP_TICK, (i % 2) ? '1 : '0, (i % 2) ? '1 : '0, (i % 2) ? '1 : '0);
		// Overwrite to off, clear everything, and scan the blank row.
		send_word(OP_WRITE, 3'd3, 3'd2, LVL_OFF);
		send_word(OP_CLEAR, '0, '0, LVL_OFF);
		send_word(OP_TICK, '0, '0, LVL_OFF);
		drain();

		run_phase(1'b1, PHASE_WORDS);
		// The receiver holds off for a long stretch so the block backs up its input.
		long_hold_req = 1'b1;
		run_phase(1'b0, PHASE_WORDS);
		run_phase(1'b1, PHASE_WORDS);
		run_phase(1'b0, PHASE_WORDS);
		no_idle = 1'b1;
		run_phase(1'b1, PHASE_WORDS);

		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
